[rtl/core/fcbf_pkg.sv]
// Shared constants, codes and types of the flow controlled byte FIFO.
package fcbf_pkg;

   // Store geometry (power of two)
   localparam int DEPTH  = 4096;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   // Field widths of the channels
   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int TOTAL_W  = 64;

   // Reset value of the capacity register
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(4096);

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_END   = 3'd4;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_out;
   } ctrl_cmd_type;

endpackage

[rtl/core/fcbf_if.sv]
// Request and response channel interfaces of the flow controlled byte FIFO.
interface fcbf_req_if;
   logic                           valid;
   logic                           ready;
   logic [fcbf_pkg::ACTION_W-1:0]  action;
   logic [fcbf_pkg::BYTE_W-1:0]    data_in;
   logic [fcbf_pkg::COUNT_W-1:0]   amount;

   modport source (output valid, output action, output data_in, output amount, input ready);
   modport sink   (input valid, input action, input data_in, input amount, output ready);
endinterface

interface fcbf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fcbf_pkg::BYTE_W-1:0]    data_out;
   logic                           data_valid;
   logic [fcbf_pkg::COUNT_W-1:0]   moved_count;
   logic [fcbf_pkg::COUNT_W-1:0]   fill_level;
   logic [fcbf_pkg::COUNT_W-1:0]   space_left;
   logic [fcbf_pkg::TOTAL_W-1:0]   total_written;
   logic [fcbf_pkg::TOTAL_W-1:0]   total_read;
   logic                           ended;
   logic                           end_of_stream;

   modport source (output valid, output data_out, output data_valid, output moved_count,
                   output fill_level, output space_left, output total_written,
                   output total_read, output ended, output end_of_stream, input ready);
   modport sink   (input valid, input data_out, input data_valid, input moved_count,
                   input fill_level, input space_left, input total_written,
                   input total_read, input ended, input end_of_stream, output ready);
endinterface

[rtl/core/fcbf_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module fcbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fcbf_ctrl.sv]
// Controller state machine: sequences accept, execute and result load.
module fcbf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcbf_pkg::ctrl_cmd_type cmd
);

   fcbf_pkg::ctrl_state_type state_ff, state_in;
   logic                     out_valid_ff, out_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcbf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         fcbf_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = fcbf_pkg::ST_EXEC;
            end
         end
         fcbf_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = fcbf_pkg::ST_FINISH;
         end
         fcbf_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = fcbf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcbf_pkg::ST_IDLE;
         end
      endcase

      // set on load, drop when the beat is taken
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

[rtl/core/fcbf_datapath.sv]
// Datapath: byte store, pointers, counters, capacity register and result register.
module fcbf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  fcbf_pkg::ctrl_cmd_type          cmd,
   input  logic                            csr_write_enable,
   input  logic [fcbf_pkg::COUNT_W-1:0]    csr_write_data,
   input  logic [fcbf_pkg::ACTION_W-1:0]   req_action,
   input  logic [fcbf_pkg::BYTE_W-1:0]     req_data_in,
   input  logic [fcbf_pkg::COUNT_W-1:0]    req_amount,
   output logic [fcbf_pkg::BYTE_W-1:0]     rsp_data_out,
   output logic                            rsp_data_valid,
   output logic [fcbf_pkg::COUNT_W-1:0]    rsp_moved_count,
   output logic [fcbf_pkg::COUNT_W-1:0]    rsp_fill_level,
   output logic [fcbf_pkg::COUNT_W-1:0]    rsp_space_left,
   output logic [fcbf_pkg::TOTAL_W-1:0]    rsp_total_written,
   output logic [fcbf_pkg::TOTAL_W-1:0]    rsp_total_read,
   output logic                            rsp_ended,
   output logic                            rsp_end_of_stream
);

   localparam int FW = fcbf_pkg::FILL_W;
   localparam int AW = fcbf_pkg::ADDR_W;
   localparam int CW = fcbf_pkg::COUNT_W;
   localparam int TW = fcbf_pkg::TOTAL_W;

   // Captured item
   logic [fcbf_pkg::ACTION_W-1:0] action_ff;
   logic [fcbf_pkg::BYTE_W-1:0]   data_ff;
   logic [CW-1:0]                 amount_ff;

   // Control state
   logic [CW-1:0] capacity_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [TW-1:0] written_ff, written_in;
   logic [TW-1:0] read_ff, read_in;
   logic          done_ff, done_in;

   // Per-item results
   logic          dvalid_ff, dvalid_in;
   logic [FW-1:0] moved_ff, moved_in;

   // Output register
   logic [fcbf_pkg::BYTE_W-1:0] out_data_ff;
   logic                        out_dvalid_ff;
   logic [CW-1:0]               out_moved_ff, out_fill_ff, out_space_ff;
   logic [TW-1:0]               out_written_ff, out_read_ff;
   logic                        out_ended_ff, out_eos_ff;

   // Store interface
   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [fcbf_pkg::BYTE_W-1:0] ram_rd_data;

   logic [FW-1:0] cap_eff;
   logic [FW-1:0] amount_w;
   logic          has_room, amount_in_fill;
   logic [FW-1:0] space;

   // Effective capacity saturates at the store depth
   always_comb begin
      if (FW'(capacity_ff) > FW'(fcbf_pkg::DEPTH) || (CW > FW && capacity_ff > CW'(fcbf_pkg::DEPTH))) begin
         cap_eff = FW'(fcbf_pkg::DEPTH);
      end else begin
         cap_eff = FW'(capacity_ff);
      end
   end

   assign amount_w       = FW'(amount_ff);
   assign has_room       = fill_ff < cap_eff;
   assign amount_in_fill = (FW > CW || amount_ff >> FW == '0) && (amount_w < fill_ff);

   // Execute the captured action
   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      written_in  = written_ff;
      read_in     = read_ff;
      done_in     = done_ff;
      dvalid_in   = 1'b0;
      moved_in    = '0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_wr_addr = head_ff + AW'(fill_ff);
      ram_rd_addr = head_ff;
      case (action_ff)
         fcbf_pkg::ACT_WRITE: begin
            if (has_room) begin
               ram_we     = cmd.execute;
               fill_in    = fill_ff + FW'(1);
               written_in = written_ff + TW'(1);
               moved_in   = FW'(1);
            end
         end
         fcbf_pkg::ACT_READ: begin
            if (fill_ff != '0) begin
               ram_re    = cmd.execute;
               dvalid_in = 1'b1;
               moved_in  = FW'(1);
               head_in   = head_ff + AW'(1);
               fill_in   = fill_ff - FW'(1);
               read_in   = read_ff + TW'(1);
            end
         end
         fcbf_pkg::ACT_PEEK: begin
            ram_rd_addr = head_ff + AW'(amount_ff);
            if (amount_in_fill) begin
               ram_re    = cmd.execute;
               dvalid_in = 1'b1;
            end
         end
         fcbf_pkg::ACT_POP: begin
            // drop at most what is held
            moved_in = amount_in_fill ? amount_w : fill_ff;
            head_in  = head_ff + AW'(moved_in);
            fill_in  = fill_ff - moved_in;
            read_in  = read_ff + TW'(moved_in);
         end
         fcbf_pkg::ACT_END: begin
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= fcbf_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         data_ff   <= req_data_in;
         amount_ff <= req_amount;
      end
   end

   // Advance pointers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         fill_ff    <= '0;
         written_ff <= '0;
         read_ff    <= '0;
         done_ff    <= 1'b0;
      end else if (cmd.execute) begin
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         written_ff <= written_in;
         read_ff    <= read_in;
         done_ff    <= done_in;
      end
   end

   // Hold per-item results until the read data returns
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         dvalid_ff <= dvalid_in;
         moved_ff  <= moved_in;
      end
   end

   // Free space from the updated fill
   assign space = (cap_eff > fill_ff) ? (cap_eff - fill_ff) : '0;

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff    <= dvalid_ff ? ram_rd_data : '0;
         out_dvalid_ff  <= dvalid_ff;
         out_moved_ff   <= CW'(moved_ff);
         out_fill_ff    <= CW'(fill_ff);
         out_space_ff   <= CW'(space);
         out_written_ff <= written_ff;
         out_read_ff    <= read_ff;
         out_ended_ff   <= done_ff;
         out_eos_ff     <= done_ff && (fill_ff == '0);
      end
   end

   fcbf_ram #(
      .WIDTH (fcbf_pkg::BYTE_W),
      .DEPTH (fcbf_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (data_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_data_out      = out_data_ff;
   assign rsp_data_valid    = out_dvalid_ff;
   assign rsp_moved_count   = out_moved_ff;
   assign rsp_fill_level    = out_fill_ff;
   assign rsp_space_left    = out_space_ff;
   assign rsp_total_written = out_written_ff;
   assign rsp_total_read    = out_read_ff;
   assign rsp_ended         = out_ended_ff;
   assign rsp_end_of_stream = out_eos_ff;

endmodule

[rtl/core/flow_controlled_byte_fifo.sv]
// Top level of the flow controlled byte FIFO: controller, datapath and checks.
//
// Usage: each beat on the req channel carries one action (write, read, peek,
// pop, end input) with a byte and an amount; each accepted beat produces one
// beat on the rsp channel with the read or peeked byte and the fill, free
// space, running totals and end flags after the action. The csr write port
// sets the capacity limit; write it only while no beat is in flight.
// Timing: a beat is accepted in the idle state, executed the next cycle
// (store write or store read issue, counters updated), and its result is
// loaded into the output register in the finish state, once that register is
// free, and the result beat is then shown on rsp by that register. The
// controller takes the next beat in the cycle after the load, so a new
// beat is not taken before the last one has passed the accept, execute and
// load steps of the controller.
// Stall: while rsp is held, the output register keeps its beat; one more item
// may be accepted and executed, then it waits until the output is taken.
// Reset: synchronous; clears the fill, head, totals and end flag and sets the
// capacity to the full store. The store itself is not cleared.
module flow_controlled_byte_fifo (
   input  logic                         clock,
   input  logic                         reset,
   fcbf_req_if.sink                     req,
   fcbf_rsp_if.source                   rsp,
   input  logic                         csr_write_enable,
   input  logic [fcbf_pkg::COUNT_W-1:0] csr_write_data
);

   fcbf_pkg::ctrl_cmd_type cmd;

   fcbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   fcbf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_action        (req.action),
      .req_data_in       (req.data_in),
      .req_amount        (req.amount),
      .rsp_data_out      (rsp.data_out),
      .rsp_data_valid    (rsp.data_valid),
      .rsp_moved_count   (rsp.moved_count),
      .rsp_fill_level    (rsp.fill_level),
      .rsp_space_left    (rsp.space_left),
      .rsp_total_written (rsp.total_written),
      .rsp_total_read    (rsp.total_read),
      .rsp_ended         (rsp.ended),
      .rsp_end_of_stream (rsp.end_of_stream)
   );

   // An accepted beat closes the request side until its result is loaded
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while an item is in flight");

   // End of stream only when ended and empty
   a_eos_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.end_of_stream |-> rsp.ended && (rsp.fill_level == '0))
      else $error("end of stream without ended and empty store");

   // Missing byte reads as zero
   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data_valid |-> (rsp.data_out == '0))
      else $error("data out nonzero without a valid byte");

   // Fill plus free space never exceeds the store
   a_space_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({1'b0, rsp.fill_level} + {1'b0, rsp.space_left}
                     <= (fcbf_pkg::COUNT_W + 1)'(fcbf_pkg::DEPTH)))
      else $error("fill and free space exceed the store depth");

endmodule
